/* hdl/sbfp_pkg.sv */
`default_nettype none

package sbfp_pkg;

    localparam int CHAN_W      = 11;
    localparam int FRAME_BYTES = 25;
    localparam int FRAME_W     = FRAME_BYTES * 8;
    localparam int IDX_W       = $clog2(FRAME_BYTES);

    localparam logic [IDX_W-1:0]  LAST_IDX    = IDX_W'(FRAME_BYTES - 1);
    localparam logic [7:0]        HEADER_BYTE = 8'h0F;
    localparam logic [7:0]        FLAGS_BYTE  = 8'h00;
    localparam logic [7:0]        FOOTER_BYTE = 8'h00;
    localparam logic [CHAN_W-1:0] FILL_RESET  = 11'd993;
    localparam logic [CHAN_W-1:0] US_MIN      = 11'd1000;
    localparam logic [CHAN_W-1:0] US_MAX      = 11'd2000;
    localparam logic [CHAN_W-1:0] OUT_MIN     = 11'd178;

    // ceil(1.633 * 2**20); exact floor(d * 1633 / 1000) for d in 0..1000.
    localparam logic [20:0]       SCALE_MUL   = 21'd1712325;
    localparam int                SCALE_SHIFT = 20;

    typedef struct packed {
        logic [CHAN_W-1:0] elevator_us;
        logic [CHAN_W-1:0] aileron_us;
        logic [CHAN_W-1:0] throttle_us;
        logic [CHAN_W-1:0] rudder_us;
        logic [CHAN_W-1:0] switch_a;
        logic [CHAN_W-1:0] switch_b;
        logic [CHAN_W-1:0] switch_c;
        logic [CHAN_W-1:0] switch_d;
    } in_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } out_t;

endpackage

`default_nettype wire

/* hdl/sbfp_scale.sv */
`default_nettype none

module sbfp_scale (
    input  wire logic [sbfp_pkg::CHAN_W-1:0] stick_us,
    output logic      [sbfp_pkg::CHAN_W-1:0] chan_value
);

    logic [9:0]  delta;
    logic [30:0] prod;

    always_comb begin
        if (stick_us < sbfp_pkg::US_MIN) begin
            delta = 10'd0;
        end else if (stick_us > sbfp_pkg::US_MAX) begin
            delta = 10'd1000;
        end else begin
            delta = 10'(stick_us - sbfp_pkg::US_MIN);
        end
    end

    assign prod       = 31'(delta) * 31'(sbfp_pkg::SCALE_MUL);
    assign chan_value = sbfp_pkg::CHAN_W'(prod[30:sbfp_pkg::SCALE_SHIFT]) + sbfp_pkg::OUT_MIN;

endmodule

`default_nettype wire

/* hdl/sbus_frame_packer.sv */
// The first byte of a frame is presented once its request has passed the input
// register and been loaded into the frame register, when the byte output is free.
// Frames of 25 bytes leave a serializer that gives one byte per cycle while m_ready
// is high; a following request is held in the input register meanwhile.
// Reset (aresetn low, synchronous) empties both registers and sets fill_reg to 993.
`default_nettype none

module sbus_frame_packer (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire sbfp_pkg::in_t                   s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output sbfp_pkg::out_t                       m_data,
    input  wire logic                            cfg_wr_en,
    input  wire logic [sbfp_pkg::CHAN_W-1:0]     cfg_wr_data
);

    sbfp_pkg::in_t                       in_reg;
    logic                                in_valid_reg;
    logic [sbfp_pkg::CHAN_W-1:0]         fill_reg;
    logic [sbfp_pkg::FRAME_W-1:0]        frame_reg;
    logic [sbfp_pkg::FRAME_W-1:0]        frame_next;
    logic [sbfp_pkg::IDX_W-1:0]          cnt_reg;
    logic                                busy_reg;
    logic                                is_last;
    logic                                out_take;
    logic                                load;
    logic [sbfp_pkg::CHAN_W-1:0]         ail_ch;
    logic [sbfp_pkg::CHAN_W-1:0]         ele_ch;
    logic [sbfp_pkg::CHAN_W-1:0]         thr_ch;
    logic [sbfp_pkg::CHAN_W-1:0]         rud_ch;

    sbfp_scale u_scale_ail (.stick_us(in_reg.aileron_us),  .chan_value(ail_ch));
    sbfp_scale u_scale_ele (.stick_us(in_reg.elevator_us), .chan_value(ele_ch));
    sbfp_scale u_scale_thr (.stick_us(in_reg.throttle_us), .chan_value(thr_ch));
    sbfp_scale u_scale_rud (.stick_us(in_reg.rudder_us),   .chan_value(rud_ch));

    assign is_last  = (cnt_reg == sbfp_pkg::LAST_IDX);
    assign out_take = busy_reg && m_ready;
    assign load     = in_valid_reg && (!busy_reg || (out_take && is_last));
    assign s_ready  = !in_valid_reg || load;

    assign m_valid           = busy_reg;
    assign m_data.frame_byte = frame_reg[7:0];
    assign m_data.last_byte  = is_last;

    // Channels are packed LSB first, channel one right after the header.
    assign frame_next = {sbfp_pkg::FOOTER_BYTE, sbfp_pkg::FLAGS_BYTE,
                         fill_reg, fill_reg, fill_reg, fill_reg,
                         fill_reg, fill_reg, fill_reg, fill_reg,
                         in_reg.switch_d, in_reg.switch_c, in_reg.switch_b, in_reg.switch_a,
                         rud_ch, thr_ch, ele_ch, ail_ch,
                         sbfp_pkg::HEADER_BYTE};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= sbfp_pkg::FILL_RESET;
        end else if (cfg_wr_en) begin
            fill_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (load) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (load) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (out_take) begin
            if (is_last) begin
                busy_reg <= 1'b0;
                cnt_reg  <= '0;
            end else begin
                cnt_reg <= cnt_reg + sbfp_pkg::IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            frame_reg <= frame_next;
        end else if (out_take) begin
            frame_reg <= {8'h00, frame_reg[sbfp_pkg::FRAME_W-1:8]};
        end
    end

    a_load_starts_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> busy_reg && (cnt_reg == '0))
        else $error("frame load did not restart the byte count");

    a_byte_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        out_take && !is_last |=> busy_reg && (cnt_reg == $past(cnt_reg) + sbfp_pkg::IDX_W'(1)))
        else $error("byte count did not advance on a taken byte");

    a_frame_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        out_take && is_last && !in_valid_reg |=> !busy_reg)
        else $error("serializer stayed busy after the footer byte");

    a_idle_count: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (cnt_reg == '0))
        else $error("byte count not cleared while idle");

    a_request_held: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> in_valid_reg)
        else $error("accepted request was not captured");

endmodule

`default_nettype wire
